// ===== sv/rmq_pkg.sv =====
// Shared types and branch codes for the rotation matrix to quaternion block.
package rmq_pkg;

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   // Control that travels beside the data through every stage.
   typedef struct packed {
      logic       valid;
      logic [1:0] branch;
      logic       bad;
      logic [3:0] neg;
   } rmq_ctl_type;

endpackage

// ===== sv/rmq_select.sv =====
// Branch selection and scaled quaternion vector, one register stage.
module rmq_select #(
   parameter int FRAC_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [15:0]       m00,
   input  logic signed [15:0]       m01,
   input  logic signed [15:0]       m02,
   input  logic signed [15:0]       m10,
   input  logic signed [15:0]       m11,
   input  logic signed [15:0]       m12,
   input  logic signed [15:0]       m20,
   input  logic signed [15:0]       m21,
   input  logic signed [15:0]       m22,
   output rmq_pkg::rmq_ctl_type     ctl_ff,
   output logic [3:0][((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2:0] v_ff
);
   import rmq_pkg::*;

   localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;

   logic signed [AW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [AW-1:0] one_w, trace, arg;
   logic signed [AW-1:0] v0, v1, v2, v3;
   logic [1:0]           br;
   rmq_ctl_type          ctl_in;
   logic [3:0][AW-1:0]   v_in;

   always_comb begin
      e00 = AW'(m00); e01 = AW'(m01); e02 = AW'(m02);
      e10 = AW'(m10); e11 = AW'(m11); e12 = AW'(m12);
      e20 = AW'(m20); e21 = AW'(m21); e22 = AW'(m22);
      one_w = AW'(1) <<< FRAC_BITS;
      trace = e00 + e11 + e22;
      priority if (trace > 0) begin
         br  = BR_TRACE;
         arg = one_w + trace;
         v0 = e21 - e12; v1 = e02 - e20; v2 = e10 - e01; v3 = arg;
      end else if (m00 > m11 && m00 > m22) begin
         br  = BR_X;
         arg = one_w + e00 - e11 - e22;
         v0 = arg; v1 = e01 + e10; v2 = e02 + e20; v3 = e21 - e12;
      end else if (m11 > m22) begin
         br  = BR_Y;
         arg = one_w + e11 - e00 - e22;
         v0 = e01 + e10; v1 = arg; v2 = e12 + e21; v3 = e02 - e20;
      end else begin
         br  = BR_Z;
         arg = one_w + e22 - e00 - e11;
         v0 = e02 + e20; v1 = e12 + e21; v2 = arg; v3 = e10 - e01;
      end
      ctl_in.valid  = in_valid;
      ctl_in.branch = br;
      ctl_in.bad    = (arg <= 0);
      ctl_in.neg    = {v3[AW-1], v2[AW-1], v1[AW-1], v0[AW-1]};
      v_in = {v3, v2, v1, v0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.branch <= ctl_in.branch;
      ctl_ff.bad    <= ctl_in.bad;
      ctl_ff.neg    <= ctl_in.neg;
      v_ff          <= v_in;
   end

endmodule

// ===== sv/rmq_norm.sv =====
// Magnitudes, squares and the squared norm, two register stages.
module rmq_norm #(
   parameter int FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rmq_pkg::rmq_ctl_type ctl_i,
   input  logic [3:0][((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2:0] v_i,
   output rmq_pkg::rmq_ctl_type ctl_ff,
   output logic [2*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) + 1:0] s_ff,
   output logic [3:0][2*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) - 1:0] sq_ff
);
   import rmq_pkg::*;

   localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
   localparam int NW = AW - 1;
   localparam int SW = 2 * NW + 2;

   rmq_ctl_type          ctl_b_ff;
   logic [3:0][2*NW-1:0] sqb_in, sqb_ff;
   logic [SW-1:0]        s_in;
   logic [NW-1:0]        mag;

   always_comb begin
      mag = '0;
      for (int l = 0; l < 4; l++) begin
         mag = v_i[l][AW-1] ? NW'(-$signed(v_i[l])) : v_i[l][NW-1:0];
         sqb_in[l] = mag * mag;
      end
      s_in = SW'(sqb_ff[0]) + SW'(sqb_ff[1]) + SW'(sqb_ff[2]) + SW'(sqb_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff.valid <= 1'b0;
         ctl_ff.valid   <= 1'b0;
      end else begin
         ctl_b_ff.valid <= ctl_i.valid;
         ctl_ff.valid   <= ctl_b_ff.valid;
      end
      ctl_b_ff.branch <= ctl_i.branch;
      ctl_b_ff.bad    <= ctl_i.bad;
      ctl_b_ff.neg    <= ctl_i.neg;
      sqb_ff          <= sqb_in;
      ctl_ff.branch   <= ctl_b_ff.branch;
      ctl_ff.bad      <= ctl_b_ff.bad || (s_in == '0);
      ctl_ff.neg      <= ctl_b_ff.neg;
      s_ff            <= s_in;
      sq_ff           <= sqb_ff;
   end

endmodule

// ===== sv/rmq_step.sv =====
// One bit of the rounded inverse square root ratio for all four components.
module rmq_step #(
   parameter int FRAC_BITS = 14,
   parameter int K         = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rmq_pkg::rmq_ctl_type ctl_i,
   input  logic [2*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) + 1:0] s_i,
   input  logic [3:0][2*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) - 1:0] sq_i,
   input  logic [3:0][4*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) + 2*FRAC_BITS + 6:0] p_i,
   input  logic [3:0][4*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) + 2*FRAC_BITS + 6:0] u_i,
   input  logic [3:0][FRAC_BITS:0] q_i,
   output rmq_pkg::rmq_ctl_type ctl_ff,
   output logic [2*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) + 1:0] s_ff,
   output logic [3:0][2*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) - 1:0] sq_ff,
   output logic [3:0][4*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) + 2*FRAC_BITS + 6:0] p_ff,
   output logic [3:0][4*(((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2) + 2*FRAC_BITS + 6:0] u_ff,
   output logic [3:0][FRAC_BITS:0] q_ff
);
   import rmq_pkg::*;

   localparam int NW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
   localparam int SW = 2 * NW + 2;
   localparam int CW = 4 * NW + 2 * FRAC_BITS + 7;

   // P holds (2q-1)^2*s, U holds (2q-1)*s; setting bit K adds d = 2^(K+1) to 2q-1.
   logic signed [CW-1:0]   sw, ps, us, cand, rhs;
   logic [3:0][CW-1:0]     p_in, u_in;
   logic [3:0][FRAC_BITS:0] q_in;

   always_comb begin
      sw = CW'(s_i);
      for (int l = 0; l < 4; l++) begin
         ps   = $signed(p_i[l]);
         us   = $signed(u_i[l]);
         cand = ps + (us <<< (K + 2)) + (sw <<< (2 * K + 2));
         rhs  = $signed(CW'(sq_i[l]) << (2 * FRAC_BITS + 2));
         if (cand <= rhs) begin
            p_in[l] = cand;
            u_in[l] = us + (sw <<< (K + 1));
            q_in[l] = q_i[l] | ((FRAC_BITS + 1)'(1) << K);
         end else begin
            p_in[l] = p_i[l];
            u_in[l] = u_i[l];
            q_in[l] = q_i[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_i.valid;
      end
      ctl_ff.branch <= ctl_i.branch;
      ctl_ff.bad    <= ctl_i.bad;
      ctl_ff.neg    <= ctl_i.neg;
      s_ff          <= s_i;
      sq_ff         <= sq_i;
      p_ff          <= p_in;
      u_ff          <= u_in;
      q_ff          <= q_in;
   end

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// A start transfer passes the select, norm and search stages and the output register before rsp_valid.
// Throughput: one matrix per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the bit-serial root/divide search: one stage per result bit.
// The receiver cannot stall: every result is shown for one cycle with rsp_valid.
// Synchronous reset clears the stage valid bits only; no clearing pass is needed.
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_qx,
   output logic signed [15:0] rsp_qy,
   output logic signed [15:0] rsp_qz,
   output logic signed [15:0] rsp_qw,
   output logic [1:0]         rsp_branch,
   output logic               rsp_invalid
);
   import rmq_pkg::*;

   localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
   localparam int NW = AW - 1;
   localparam int SW = 2 * NW + 2;
   localparam int CW = 4 * NW + 2 * FRAC_BITS + 7;
   localparam int NS = FRAC_BITS + 1;
   // Wide enough for the signed ratio and for the 16-bit saturation limits.
   localparam int QW = (FRAC_BITS > 15) ? FRAC_BITS + 2 : 17;

   rmq_ctl_type           sel_ctl;
   logic [3:0][AW-1:0]    sel_v;

   rmq_ctl_type           ctl_st [0:NS];
   logic [SW-1:0]         s_st   [0:NS];
   logic [3:0][2*NW-1:0]  sq_st  [0:NS];
   logic [3:0][CW-1:0]    p_st   [0:NS];
   logic [3:0][CW-1:0]    u_st   [0:NS];
   logic [3:0][FRAC_BITS:0] q_st [0:NS];

   logic [3:0][15:0]      q_out_in;
   logic [QW-1:0]         qe;
   logic signed [QW-1:0]  qs;
   logic                  valid_ff;
   logic [3:0][15:0]      q_out_ff;
   logic [1:0]            branch_ff;
   logic                  invalid_ff;

   assign busy = 1'b0;

   rmq_select #(.FRAC_BITS(FRAC_BITS)) u_select (
      .clock(clock), .reset(reset), .in_valid(start),
      .m00(req_m00), .m01(req_m01), .m02(req_m02),
      .m10(req_m10), .m11(req_m11), .m12(req_m12),
      .m20(req_m20), .m21(req_m21), .m22(req_m22),
      .ctl_ff(sel_ctl), .v_ff(sel_v)
   );

   rmq_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
      .clock(clock), .reset(reset), .ctl_i(sel_ctl), .v_i(sel_v),
      .ctl_ff(ctl_st[0]), .s_ff(s_st[0]), .sq_ff(sq_st[0])
   );

   // Search starts at q = 0, where 2q-1 = -1.
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         p_st[0][l] = CW'(s_st[0]);
         u_st[0][l] = -CW'(s_st[0]);
         q_st[0][l] = '0;
      end
   end

   for (genvar j = 0; j < NS; j++) begin : g_step
      rmq_step #(.FRAC_BITS(FRAC_BITS), .K(FRAC_BITS - j)) u_step (
         .clock(clock), .reset(reset),
         .ctl_i(ctl_st[j]), .s_i(s_st[j]), .sq_i(sq_st[j]),
         .p_i(p_st[j]), .u_i(u_st[j]), .q_i(q_st[j]),
         .ctl_ff(ctl_st[j+1]), .s_ff(s_st[j+1]), .sq_ff(sq_st[j+1]),
         .p_ff(p_st[j+1]), .u_ff(u_st[j+1]), .q_ff(q_st[j+1])
      );
   end

   // Sign, saturate, zero on invalid.
   always_comb begin
      qe = '0;
      qs = '0;
      for (int l = 0; l < 4; l++) begin
         qe = QW'(q_st[NS][l]);
         qs = ctl_st[NS].neg[l] ? -$signed(qe) : $signed(qe);
         if (ctl_st[NS].bad) begin
            q_out_in[l] = '0;
         end else if (qs > $signed(QW'(32767))) begin
            q_out_in[l] = 16'h7fff;
         end else if (qs < -$signed(QW'(32768))) begin
            q_out_in[l] = 16'h8000;
         end else begin
            q_out_in[l] = qs[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_st[NS].valid;
      end
      q_out_ff   <= q_out_in;
      branch_ff  <= ctl_st[NS].branch;
      invalid_ff <= ctl_st[NS].bad;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_qx      = q_out_ff[0];
   assign rsp_qy      = q_out_ff[1];
   assign rsp_qz      = q_out_ff[2];
   assign rsp_qw      = q_out_ff[3];
   assign rsp_branch  = branch_ff;
   assign rsp_invalid = invalid_ff;

endmodule
